@@ rtl/cfp_pkg.sv @@
`timescale 1ns / 1ps

package cfp_pkg;

   // Counter width; outputs show the low RSP_COUNT_W bits
   localparam int COUNT_WIDTH = 16;
   localparam int RSP_COUNT_W = 16;
   localparam int TIME_W      = 32;
   localparam int TIMEOUT_W   = 16;

   localparam logic [7:0] SYNC_FIRST  = 8'hA5;
   localparam logic [7:0] SYNC_SECOND = 8'h5A;
   localparam logic [7:0] CMD_MAX     = 8'd12;
   localparam logic [7:0] CMD_MIN     = 8'd1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

   // Item kinds
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_CHECK = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SYNC1 = 2'd1,
      PH_SYNC2 = 2'd2,
      PH_CMD   = 2'd3
   } phase_type;

   typedef struct packed {
      phase_type               phase;
      logic [3:0]              held_command;
      logic [TIME_W-1:0]       last_byte_time;
      logic [COUNT_WIDTH-1:0]  errors_seen;
      logic [COUNT_WIDTH-1:0]  frames_seen;
      logic [COUNT_WIDTH-1:0]  bytes_seen;
      logic [3:0]              newest_command;
   } parser_state_type;

   localparam parser_state_type STATE_RESET = '{
      phase:          PH_IDLE,
      held_command:   4'd0,
      last_byte_time: '0,
      errors_seen:    '0,
      frames_seen:    '0,
      bytes_seen:     '0,
      newest_command: 4'd0
   };

endpackage

@@ rtl/cfp_update.sv @@
`timescale 1ns / 1ps

module cfp_update
   import cfp_pkg::*;
(
   input  parser_state_type       cur_state,
   input  logic                   item_cmd,
   input  logic [7:0]             item_byte,
   input  logic [TIME_W-1:0]      item_time,
   input  logic [TIMEOUT_W-1:0]   timeout_ticks,
   output parser_state_type       next_state,
   output logic [3:0]             done_command
);

   logic [TIME_W-1:0]       diff;
   logic                    expired;
   phase_type               ph_after_to;
   logic [COUNT_WIDTH-1:0]  err_after_to;
   logic                    bad_byte;
   logic                    cmd_in_range;
   logic [7:0]              cmd_compl;

   // Timeout check: wrapped signed difference is non-negative
   assign diff    = item_time - cur_state.last_byte_time - TIME_W'(timeout_ticks);
   assign expired = (cur_state.phase != PH_IDLE) && !diff[TIME_W-1];

   assign ph_after_to  = expired ? PH_IDLE : cur_state.phase;
   assign err_after_to = expired ? cur_state.errors_seen + 1'b1 : cur_state.errors_seen;

   assign cmd_in_range = (item_byte >= CMD_MIN) && (item_byte <= CMD_MAX);
   assign cmd_compl    = ~{4'd0, cur_state.held_command};

   // Parser step: timeout check for every item, byte handling for byte items
   always_comb begin
      next_state          = cur_state;
      next_state.phase    = ph_after_to;
      next_state.errors_seen = err_after_to;
      done_command        = 4'd0;
      bad_byte            = 1'b0;
      if (item_cmd == KIND_BYTE) begin
         next_state.last_byte_time = item_time;
         next_state.bytes_seen     = cur_state.bytes_seen + 1'b1;
         case (ph_after_to)
            PH_IDLE: begin
               if (item_byte == SYNC_FIRST) next_state.phase = PH_SYNC1;
            end
            PH_SYNC1: begin
               if (item_byte == SYNC_SECOND) next_state.phase = PH_SYNC2;
               else bad_byte = 1'b1;
            end
            PH_SYNC2: begin
               if (cmd_in_range) begin
                  next_state.held_command = item_byte[3:0];
                  next_state.phase        = PH_CMD;
               end else begin
                  bad_byte = 1'b1;
               end
            end
            PH_CMD: begin
               if (item_byte == cmd_compl) begin
                  done_command              = cur_state.held_command;
                  next_state.frames_seen    = cur_state.frames_seen + 1'b1;
                  next_state.newest_command = cur_state.held_command;
                  next_state.phase          = PH_IDLE;
               end else begin
                  bad_byte = 1'b1;
               end
            end
            default: begin
               next_state.phase = PH_IDLE;
            end
         endcase
         // Resync on a bad byte mid-frame
         if (bad_byte) begin
            next_state.errors_seen = err_after_to + 1'b1;
            next_state.phase = (item_byte == SYNC_FIRST) ? PH_SYNC1 : PH_IDLE;
         end
      end
   end

endmodule

@@ rtl/command_frame_parser_top.sv @@
`timescale 1ns / 1ps

// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while rsp_ready holds; the parser state updates in the
// single pass between the input register and the result register.
// Reset (synchronous, active high): parser idle, counters and commands zero,
// timeout_ticks 100, both pipeline registers empty.
module command_frame_parser_top
   import cfp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [7:0]              req_byte_value,
   input  logic [TIME_W-1:0]       req_time_now,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_frame_command,
   output logic [3:0]              rsp_last_good_command,
   output logic [1:0]              rsp_parse_phase,
   output logic [RSP_COUNT_W-1:0]  rsp_error_count,
   output logic [RSP_COUNT_W-1:0]  rsp_frame_count,
   output logic [RSP_COUNT_W-1:0]  rsp_byte_count,
   input  logic                    csr_write_enable,
   input  logic [TIMEOUT_W-1:0]    csr_write_data
);

   logic                    in_valid_ff;
   logic                    in_cmd_ff;
   logic [7:0]              in_byte_ff;
   logic [TIME_W-1:0]       in_time_ff;
   logic [TIMEOUT_W-1:0]    timeout_ff;
   parser_state_type        state_ff;
   parser_state_type        state_in;
   logic [3:0]              done_in;
   logic                    out_valid_ff;
   logic [3:0]              out_frame_ff;
   logic [3:0]              out_last_ff;
   logic [1:0]              out_phase_ff;
   logic [RSP_COUNT_W-1:0]  out_err_ff;
   logic [RSP_COUNT_W-1:0]  out_frm_ff;
   logic [RSP_COUNT_W-1:0]  out_byt_ff;
   logic                    advance;

   // Item moves from input register to result register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   cfp_update u_update (
      .cur_state     (state_ff),
      .item_cmd      (in_cmd_ff),
      .item_byte     (in_byte_ff),
      .item_time     (in_time_ff),
      .timeout_ticks (timeout_ff),
      .next_state    (state_in),
      .done_command  (done_in)
   );

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (csr_write_enable) timeout_ff <= csr_write_data;
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_byte_value;
         in_time_ff <= req_time_now;
      end
      if (advance) begin
         out_frame_ff <= done_in;
         out_last_ff  <= state_in.newest_command;
         out_phase_ff <= state_in.phase;
         out_err_ff   <= RSP_COUNT_W'(state_in.errors_seen);
         out_frm_ff   <= RSP_COUNT_W'(state_in.frames_seen);
         out_byt_ff   <= RSP_COUNT_W'(state_in.bytes_seen);
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_frame_command     = out_frame_ff;
   assign rsp_last_good_command = out_last_ff;
   assign rsp_parse_phase       = out_phase_ff;
   assign rsp_error_count       = out_err_ff;
   assign rsp_frame_count       = out_frm_ff;
   assign rsp_byte_count        = out_byt_ff;

`ifndef ASSERT_OFF
   // Parser state only moves when an item passes through
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("parser state changed without an item");

   // A completed frame leaves the parser idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_command != 4'd0) |-> (rsp_parse_phase == PH_IDLE))
      else $error("frame completed but parser not idle");

   // A completed frame bumps the frame counter by one
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      (advance && done_in != 4'd0) |=>
      (state_ff.frames_seen == $past(state_ff.frames_seen) + 1'b1))
      else $error("frame counter did not advance");

   // Errors grow by at most two per item (timeout plus bad byte)
   a_err_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> (state_ff.errors_seen == $past(state_ff.errors_seen)) ||
                  (state_ff.errors_seen == $past(state_ff.errors_seen) + 1'b1) ||
                  (state_ff.errors_seen == $past(state_ff.errors_seen) + 2'd2))
      else $error("error counter jumped");
`endif

endmodule
